>>> rtl/core/sbb_pkg.sv
`default_nettype none

package sbb_pkg;

   // Frame geometry limits
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MIN_DIM    = 4;

   localparam int CFG_W     = 9;
   localparam int DIM_W_W   = $clog2(MAX_WIDTH + 1);
   localparam int DIM_H_W   = $clog2(MAX_HEIGHT + 1);
   localparam int X_W       = $clog2(MAX_WIDTH);
   localparam int Y_W       = $clog2(MAX_HEIGHT);
   localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int DIV_CNT_W = $clog2(CNT_W);

   // Pixel and filter arithmetic
   localparam int CH_W    = 8;
   localparam int PIX_W   = 3 * CH_W;
   localparam int TAPS    = 5;
   localparam int TAP_W   = 3;
   localparam int CENTRE  = 2;
   localparam int SUM_W   = 12;
   localparam int SHIFT   = 4;
   localparam int ROUND   = 8;

   // Configuration port
   localparam int PADDR_W   = 3;
   localparam int PDATA_W   = 32;
   localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // Request kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_FETCH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_INIT,
      ST_ROW,
      ST_READ,
      ST_DRAIN,
      ST_DONE
   } sbb_state_type;

   typedef struct packed {
      logic [DIM_W_W-1:0] width;
      logic [DIM_H_W-1:0] height;
      logic [CNT_W-1:0]   total;
   } sbb_geom_type;

   typedef struct packed {
      logic             valid;
      logic [TAP_W-1:0] tap;
      logic [TAP_W-1:0] row;
   } sbb_tag_type;

   function automatic logic [DIM_W_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
      logic [DIM_W_W-1:0] r;
      if (v < CFG_W'(MIN_DIM)) begin
         r = DIM_W_W'(MIN_DIM);
      end else if (32'(v) > MAX_WIDTH) begin
         r = DIM_W_W'(MAX_WIDTH);
      end else begin
         r = DIM_W_W'(v);
      end
      return r;
   endfunction

   function automatic logic [DIM_H_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
      logic [DIM_H_W-1:0] r;
      if (v < CFG_W'(MIN_DIM)) begin
         r = DIM_H_W'(MIN_DIM);
      end else if (32'(v) > MAX_HEIGHT) begin
         r = DIM_H_W'(MAX_HEIGHT);
      end else begin
         r = DIM_H_W'(v);
      end
      return r;
   endfunction

   // Binomial weights 1 4 6 4 1
   function automatic logic [2:0] kernel(input logic [TAP_W-1:0] i);
      logic [2:0] k;
      case (i)
         3'd0, 3'd4: k = 3'd1;
         3'd1, 3'd3: k = 3'd4;
         3'd2:       k = 3'd6;
         default:    k = 3'd0;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/separable_binomial_blur_wrap_top.sv
// 5x5 binomial blur (1 4 6 4 1 in each direction, wrapping at the frame
// edges) of an RGB frame held in a single-port-read frame memory. Raise start
// with req_kind = load to write one pixel in raster order; busy stays low.
// Once a full frame is in, each start with req_kind = fetch returns the next
// blurred pixel in raster order: busy is high while the 25 neighbours are
// read one per cycle (five rows, each preceded by a row-address multiply),
// and the result is shown on the rsp_ ports for exactly one cycle with
// rsp_valid high, in the cycle in which busy falls. After the width register
// has been changed the next fetch first recovers its column and row by a
// bit-serial division. The receiver cannot stall: take each result in the
// cycle rsp_valid is high. rsp_last_pixel marks the final pixel of the frame,
// after which a new frame must be loaded. Fetches before the frame is complete
// and loads into a full frame are dropped without a result.

`default_nettype none

module separable_binomial_blur_wrap_top import sbb_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_kind,
   input  wire logic [CH_W-1:0]    req_red_in,
   input  wire logic [CH_W-1:0]    req_green_in,
   input  wire logic [CH_W-1:0]    req_blue_in,
   output logic                    rsp_valid,
   output logic      [CH_W-1:0]    rsp_red_out,
   output logic      [CH_W-1:0]    rsp_green_out,
   output logic      [CH_W-1:0]    rsp_blue_out,
   output logic                    rsp_last_pixel,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output logic      [PDATA_W-1:0] prdata,
   output logic                    pready
);

   sbb_geom_type      geom;
   sbb_tag_type       tag;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [PIX_W-1:0]  wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [PIX_W-1:0]  rd_data;
   logic [PIX_W-1:0]  result;
   logic [PIX_W-1:0]  rsp_pixel;

   sbb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .geom    (geom)
   );

   sbb_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sbb_acc u_acc (
      .clock   (clock),
      .tag     (tag),
      .rd_data (rd_data),
      .result  (result)
   );

   sbb_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_kind  (req_kind),
      .req_pixel ({req_red_in, req_green_in, req_blue_in}),
      .geom      (geom),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .tag       (tag),
      .result    (result),
      .rsp_valid (rsp_valid),
      .rsp_pixel (rsp_pixel),
      .rsp_last  (rsp_last_pixel)
   );

   assign rsp_red_out   = rsp_pixel[3*CH_W-1:2*CH_W];
   assign rsp_green_out = rsp_pixel[2*CH_W-1:CH_W];
   assign rsp_blue_out  = rsp_pixel[CH_W-1:0];

endmodule

`default_nettype wire

>>> rtl/core/sbb_csr.sv
`default_nettype none

module sbb_csr import sbb_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output logic      [PDATA_W-1:0] prdata,
   output logic                    pready,
   output sbb_geom_type            geom
);

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic             wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // Decode register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_WIDTH:  width_in  = pwdata[CFG_W-1:0];
            REG_HEIGHT: height_in = pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_RESET;
         height_ff <= CFG_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Read back
   always_comb begin
      case (paddr[2])
         REG_WIDTH:  prdata = PDATA_W'(width_ff);
         REG_HEIGHT: prdata = PDATA_W'(height_ff);
         default:    prdata = '0;
      endcase
   end

   // Geometry in use
   always_comb begin
      geom.width  = clamp_width(width_ff);
      geom.height = clamp_height(height_ff);
      geom.total  = CNT_W'(geom.width) * CNT_W'(geom.height);
   end

endmodule

`default_nettype wire

>>> rtl/core/sbb_ram.sv
`default_nettype none

module sbb_ram import sbb_pkg::*; (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [PIX_W-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [PIX_W-1:0]  rd_data
);

   logic [PIX_W-1:0] mem [0:DEPTH-1];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/sbb_acc.sv
`default_nettype none

module sbb_acc import sbb_pkg::*; (
   input  wire logic             clock,
   input  wire sbb_tag_type      tag,
   input  wire logic [PIX_W-1:0] rd_data,
   output logic      [PIX_W-1:0] result
);

   for (genvar c = 0; c < 3; c++) begin : g_chan
      logic [SUM_W-1:0] hsum_ff, hsum_in;
      logic [SUM_W-1:0] vsum_ff, vsum_in;
      logic [CH_W-1:0]  pix;
      logic [SUM_W-1:0] hterm;
      logic [SUM_W-1:0] hfull;
      logic [CH_W-1:0]  hval;
      logic [SUM_W-1:0] vterm;
      logic [SUM_W-1:0] vround;

      // Channel bits: red on top, blue at the bottom
      assign pix   = rd_data[(2 - c) * CH_W +: CH_W];
      assign hterm = SUM_W'(pix) * SUM_W'(kernel(tag.tap));
      assign hfull = hsum_ff + hterm + SUM_W'(ROUND);
      assign hval  = hfull[SUM_W-1:SHIFT];
      assign vterm = SUM_W'(hval) * SUM_W'(kernel(tag.row));

      // Accumulate the row sum, fold a finished row into the column sum
      always_comb begin
         hsum_in = hsum_ff;
         vsum_in = vsum_ff;
         if (tag.valid) begin
            hsum_in = (tag.tap == '0) ? hterm : hsum_ff + hterm;
            if (tag.tap == TAP_W'(TAPS - 1)) begin
               vsum_in = (tag.row == '0) ? vterm : vsum_ff + vterm;
            end
         end
      end

      always_ff @(posedge clock) begin
         hsum_ff <= hsum_in;
         vsum_ff <= vsum_in;
      end

      assign vround = vsum_ff + SUM_W'(ROUND);
      assign result[(2 - c) * CH_W +: CH_W] = vround[SUM_W-1:SHIFT];
   end

endmodule

`default_nettype wire

>>> rtl/core/sbb_seq.sv
`default_nettype none

module sbb_seq import sbb_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              req_kind,
   input  wire logic [PIX_W-1:0]  req_pixel,
   input  wire sbb_geom_type      geom,
   output logic                   wr_en,
   output logic      [ADDR_W-1:0] wr_addr,
   output logic      [PIX_W-1:0]  wr_data,
   output logic      [ADDR_W-1:0] rd_addr,
   output sbb_tag_type            tag,
   input  wire logic [PIX_W-1:0]  result,
   output logic                   rsp_valid,
   output logic      [PIX_W-1:0]  rsp_pixel,
   output logic                   rsp_last
);

   sbb_state_type        state_ff, state_in;
   logic [CNT_W-1:0]     load_count_ff, load_count_in;
   logic [CNT_W-1:0]     read_count_ff, read_count_in;
   logic [X_W-1:0]       x_ff, x_in;
   logic [Y_W-1:0]       y_ff, y_in;
   logic [DIM_W_W-1:0]   geo_w_ff, geo_w_in;
   logic [DIM_W_W-1:0]   div_rem_ff, div_rem_in;
   logic [CNT_W-1:0]     div_quo_ff, div_quo_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [Y_W-1:0]       ny_ff, ny_in;
   logic [X_W-1:0]       nx_ff, nx_in;
   logic [X_W-1:0]       nx0_ff, nx0_in;
   logic [TAP_W-1:0]     row_ff, row_in;
   logic [TAP_W-1:0]     tap_ff, tap_in;
   logic [ADDR_W-1:0]    row_base_ff, row_base_in;
   sbb_tag_type          tag_ff, tag_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]     rsp_pixel_ff, rsp_pixel_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 accept;
   logic                 frame_full;
   logic [DIM_W_W:0]     rem_shift;
   logic                 div_ge;
   logic [DIM_W_W:0]     rem_sub;
   logic [CNT_W-1:0]     quo_next;
   logic [DIM_H_W:0]     ny_wrap;
   logic [DIM_W_W:0]     nx_wrap;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign frame_full = (load_count_ff >= geom.total);

   // One restoring division step: remainder gives column, quotient row
   assign rem_shift = {div_rem_ff, div_quo_ff[CNT_W-1]};
   assign div_ge    = (rem_shift >= {1'b0, geom.width});
   assign rem_sub   = div_ge ? rem_shift - {1'b0, geom.width} : rem_shift;
   assign quo_next  = {div_quo_ff[CNT_W-2:0], div_ge};

   // Window start, two rows up and two columns left, wrapped
   assign ny_wrap = (DIM_H_W+1)'(y_ff) + (DIM_H_W+1)'(geom.height) - (DIM_H_W+1)'(CENTRE);
   assign nx_wrap = (DIM_W_W+1)'(x_ff) + (DIM_W_W+1)'(geom.width) - (DIM_W_W+1)'(CENTRE);

   assign wr_addr = load_count_ff[ADDR_W-1:0];
   assign wr_data = req_pixel;
   assign rd_addr = row_base_ff + ADDR_W'(nx_ff);
   assign tag     = tag_ff;

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      read_count_in = read_count_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      geo_w_in      = geo_w_ff;
      div_rem_in    = div_rem_ff;
      div_quo_in    = div_quo_ff;
      div_cnt_in    = div_cnt_ff;
      ny_in         = ny_ff;
      nx_in         = nx_ff;
      nx0_in        = nx0_ff;
      row_in        = row_ff;
      tap_in        = tap_ff;
      row_base_in   = row_base_ff;
      tag_in        = '0;
      rsp_valid_in  = 1'b0;
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_kind == KIND_LOAD && !frame_full) begin
               // Store the word and advance the fill pointer
               wr_en         = 1'b1;
               load_count_in = load_count_ff + 1'b1;
            end else if (accept && req_kind == KIND_FETCH && frame_full) begin
               if (read_count_ff >= geom.total) begin
                  read_count_in = '0;
                  x_in          = '0;
                  y_in          = '0;
                  geo_w_in      = geom.width;
                  state_in      = ST_INIT;
               end else if (geo_w_ff != geom.width) begin
                  // Width changed: rebuild column and row from the count
                  div_rem_in = '0;
                  div_quo_in = read_count_ff;
                  div_cnt_in = '0;
                  state_in   = ST_DIV;
               end else begin
                  state_in = ST_INIT;
               end
            end
         end

         ST_DIV: begin
            div_rem_in = rem_sub[DIM_W_W-1:0];
            div_quo_in = quo_next;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(CNT_W - 1)) begin
               x_in     = rem_sub[X_W-1:0];
               y_in     = quo_next[Y_W-1:0];
               geo_w_in = geom.width;
               state_in = ST_INIT;
            end
         end

         ST_INIT: begin
            ny_in  = (y_ff >= Y_W'(CENTRE)) ? y_ff - Y_W'(CENTRE) : ny_wrap[Y_W-1:0];
            nx0_in = (x_ff >= X_W'(CENTRE)) ? x_ff - X_W'(CENTRE) : nx_wrap[X_W-1:0];
            nx_in  = (x_ff >= X_W'(CENTRE)) ? x_ff - X_W'(CENTRE) : nx_wrap[X_W-1:0];
            row_in = '0;
            tap_in = '0;
            state_in = ST_ROW;
         end

         ST_ROW: begin
            row_base_in = ADDR_W'(ny_ff) * ADDR_W'(geom.width);
            state_in    = ST_READ;
         end

         ST_READ: begin
            // Issue one neighbour read; tag travels with the read data
            tag_in.valid = 1'b1;
            tag_in.tap   = tap_ff;
            tag_in.row   = row_ff;
            nx_in  = (DIM_W_W'(nx_ff) == geom.width - 1'b1) ? '0 : nx_ff + 1'b1;
            tap_in = tap_ff + 1'b1;
            if (tap_ff == TAP_W'(TAPS - 1)) begin
               tap_in = '0;
               nx_in  = nx0_ff;
               ny_in  = (DIM_H_W'(ny_ff) == geom.height - 1'b1) ? '0 : ny_ff + 1'b1;
               row_in = row_ff + 1'b1;
               state_in = (row_ff == TAP_W'(TAPS - 1)) ? ST_DRAIN : ST_ROW;
            end
         end

         ST_DRAIN: begin
            state_in = ST_DONE;
         end

         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_pixel_in = result;
            if (read_count_ff + 1'b1 == geom.total) begin
               // Frame finished: flag it and start over
               rsp_last_in   = 1'b1;
               read_count_in = '0;
               load_count_in = '0;
               x_in          = '0;
               y_in          = '0;
               geo_w_in      = geom.width;
            end else begin
               rsp_last_in   = 1'b0;
               read_count_in = read_count_ff + 1'b1;
               if (DIM_W_W'(x_ff) == geom.width - 1'b1) begin
                  x_in = '0;
                  y_in = y_ff + 1'b1;
               end else begin
                  x_in = x_ff + 1'b1;
               end
            end
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         load_count_ff <= '0;
         read_count_ff <= '0;
         x_ff          <= '0;
         y_ff          <= '0;
         geo_w_ff      <= clamp_width(CFG_RESET);
         div_cnt_ff    <= '0;
         row_ff        <= '0;
         tap_ff        <= '0;
         tag_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         read_count_ff <= read_count_in;
         x_ff          <= x_in;
         y_ff          <= y_in;
         geo_w_ff      <= geo_w_in;
         div_cnt_ff    <= div_cnt_in;
         row_ff        <= row_in;
         tap_ff        <= tap_in;
         tag_ff        <= tag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      div_rem_ff   <= div_rem_in;
      div_quo_ff   <= div_quo_in;
      ny_ff        <= ny_in;
      nx_ff        <= nx_in;
      nx0_ff       <= nx0_in;
      row_base_ff  <= row_base_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_pixel_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

`default_nettype wire

>>> rtl/core/sbb_check.sv
`default_nettype none

module sbb_check import sbb_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic req_kind,
   input wire logic rsp_valid
);

   // A result follows the end of a fetch, never overlapping work
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result word outside the end of a fetch");

   // Loads finish in their own cycle and give no result
   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == KIND_LOAD) |=> (!busy && !rsp_valid))
      else $error("load word kept the block busy or gave a result");

   // Only an accepted fetch starts work
   a_busy_from_fetch: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && req_kind == KIND_FETCH))
      else $error("busy rose without an accepted fetch");

   // Results are single-cycle strobes
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

endmodule

bind separable_binomial_blur_wrap_top sbb_check u_sbb_check (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_kind  (req_kind),
   .rsp_valid (rsp_valid)
);

`default_nettype wire

>>> verif/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sbb_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int QUIET_CYCLES = 60;
   localparam int RANDOM_ITEMS = 600;

   // Corner pixels for the directed frame: every channel at 0, 255 and mixed bit patterns
   localparam logic [15:0][PIX_W-1:0] CORNER_PIXELS = {
      24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
      24'h0000FF, 24'h808080, 24'h7F7F7F, 24'h010101,
      24'hFEFEFE, 24'hAA55AA, 24'h55AA55, 24'hFFFFFF,
      24'h000000, 24'hFF00FF, 24'h00FFFF, 24'hFFFF00
   };

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            last;
   } blurred_pixel_type;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               start          = 1'b0;
   logic               req_kind       = KIND_LOAD;
   logic [CH_W-1:0]    req_red_in     = '0;
   logic [CH_W-1:0]    req_green_in   = '0;
   logic [CH_W-1:0]    req_blue_in    = '0;
   logic               psel           = 1'b0;
   logic               penable        = 1'b0;
   logic               pwrite         = 1'b0;
   logic [PADDR_W-1:0] paddr          = '0;
   logic [PDATA_W-1:0] pwdata         = '0;
   logic               busy;
   logic               rsp_valid;
   logic [CH_W-1:0]    rsp_red_out;
   logic [CH_W-1:0]    rsp_green_out;
   logic [CH_W-1:0]    rsp_blue_out;
   logic               rsp_last_pixel;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   // Shadow of the block: frame contents, counters and size registers
   logic [PIX_W-1:0] frame_copy [0:DEPTH-1];
   logic [CFG_W-1:0] width_setting  = CFG_RESET;
   logic [CFG_W-1:0] height_setting = CFG_RESET;
   int               loaded_pixels  = 0;
   int               fetched_pixels = 0;
   blurred_pixel_type pending_pixels [$];

   int  loads_taken     = 0;
   int  loads_dropped   = 0;
   int  fetches_served  = 0;
   int  fetches_dropped = 0;
   int  results_checked = 0;
   int  useful_items    = 0;
   int  failures        = 0;
   int  idle_cycles     = 0;
   bit  no_gaps         = 1'b0;

   separable_binomial_blur_wrap_top uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_red_in     (req_red_in),
      .req_green_in   (req_green_in),
      .req_blue_in    (req_blue_in),
      .rsp_valid      (rsp_valid),
      .rsp_red_out    (rsp_red_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_last_pixel (rsp_last_pixel),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Size actually used: register clamped to the supported range
   function automatic int used_dim(input logic [CFG_W-1:0] v, input int limit);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > limit) return limit;
      return int'(v);
   endfunction

   function automatic int tap_weight(input int i);
      case (i)
         0, 4:    return 1;
         1, 3:    return 4;
         default: return 6;
      endcase
   endfunction

   // Horizontal 1-4-6-4-1 pass per row, then the same down the columns, both wrapping
   function automatic logic [CH_W-1:0] blur_channel(input int x, input int y, input int w,
                                                    input int h, input int ch);
      int acc_v;
      int acc_h;
      int nx;
      int ny;
      acc_v = 0;
      for (int j = 0; j < 5; j++) begin
         ny = (y + h + j - 2) % h;
         acc_h = 0;
         for (int i = 0; i < 5; i++) begin
            nx = (x + w + i - 2) % w;
            acc_h += int'((frame_copy[ny * w + nx] >> (16 - 8 * ch)) & 24'hFF) * tap_weight(i);
         end
         acc_v += ((acc_h + 8) >> 4) * tap_weight(j);
      end
      return CH_W'((acc_v + 8) >> 4);
   endfunction

   // Apply one accepted word to the shadow; queue the blurred pixel a fetch yields
   function automatic bit advance_frame_model(input logic kind, input logic [PIX_W-1:0] pixel);
      int                w;
      int                h;
      int                total;
      blurred_pixel_type res;
      w     = used_dim(width_setting, MAX_WIDTH);
      h     = used_dim(height_setting, MAX_HEIGHT);
      total = w * h;
      if (kind == KIND_LOAD) begin
         if (loaded_pixels >= total) begin
            loads_dropped++;
            return 1'b0;
         end
         frame_copy[loaded_pixels] = pixel;
         loaded_pixels++;
         loads_taken++;
         return 1'b1;
      end
      if (loaded_pixels < total) begin
         fetches_dropped++;
         return 1'b0;
      end
      // a shrunken frame restarts the read position
      if (fetched_pixels >= total) fetched_pixels = 0;
      res.red   = blur_channel(fetched_pixels % w, fetched_pixels / w, w, h, 0);
      res.green = blur_channel(fetched_pixels % w, fetched_pixels / w, w, h, 1);
      res.blue  = blur_channel(fetched_pixels % w, fetched_pixels / w, w, h, 2);
      res.last  = (fetched_pixels + 1 == total);
      if (res.last) begin
         fetched_pixels = 0;
         loaded_pixels  = 0;
      end else begin
         fetched_pixels++;
      end
      pending_pixels.push_back(res);
      fetches_served++;
      return 1'b1;
   endfunction

   function automatic logic [PIX_W-1:0] random_pixel();
      logic [PIX_W-1:0] pixel;
      pixel = PIX_W'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         pixel[23:16] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         pixel[15:8]  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         pixel[7:0]   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      return pixel;
   endfunction

   // Offer one word after a random gap (none while no_gaps is set) and hold it until the block takes it
   task automatic send_word(input logic kind, input logic [PIX_W-1:0] pixel);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_kind     <= kind;
      req_red_in   <= pixel[23:16];
      req_green_in <= pixel[15:8];
      req_blue_in  <= pixel[7:0];
      do @(posedge clock); while (busy);
      if (advance_frame_model(kind, pixel)) useful_items++;
   endtask

   // Drain outstanding pixels and let any dropped fetch finish before touching registers
   task automatic settle();
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic csr_check(input logic idx, input logic [CFG_W-1:0] want);
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[CFG_W-1:0] !== want) begin
         $error("prdata: expected %0d, got %0d", want, prdata[CFG_W-1:0]);
         failures++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_write(input logic idx, input logic [CFG_W-1:0] value);
      logic [PDATA_W-1:0] word;
      word             = $urandom;
      word[CFG_W-1:0]  = value;
      settle();
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (idx == REG_WIDTH) width_setting = value;
      else height_setting = value;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      csr_check(idx, value);
   endtask

   // Reset sizes read back, and fetches into an empty frame are dropped
   task automatic test_reset_state();
      csr_check(REG_WIDTH, CFG_RESET);
      @(posedge clock);
      csr_check(REG_HEIGHT, CFG_RESET);
      repeat (3) send_word(KIND_FETCH, random_pixel());
   endtask

   // Under-range sizes clamp to 4x4; corner pixels, loads into a full frame, whole readout
   task automatic test_directed_frame();
      csr_write(REG_WIDTH, 9'd0);
      csr_write(REG_HEIGHT, 9'd3);
      for (int i = 0; i < 16; i++) send_word(KIND_LOAD, CORNER_PIXELS[i]);
      repeat (2) send_word(KIND_LOAD, 24'hFFFFFF);
      repeat (16) send_word(KIND_FETCH, 24'h000000);
   endtask

   // Small frames with noise: early fetches, short loads, overflow loads, partial readouts
   task automatic test_random_frames();
      int goal;
      int total;
      int n_loads;
      int n_fetches;
      goal = useful_items + RANDOM_ITEMS;
      while (useful_items < goal) begin
         csr_write(REG_WIDTH, CFG_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 3)
                                                                  : $urandom_range(4, 12)));
         csr_write(REG_HEIGHT, CFG_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 3)
                                                                   : $urandom_range(4, 12)));
         total   = used_dim(width_setting, MAX_WIDTH) * used_dim(height_setting, MAX_HEIGHT);
         no_gaps = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(0, 2)) send_word(KIND_FETCH, random_pixel());
         n_loads   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total - 1) : total;
         n_fetches = ($urandom_range(0, 5) == 0) ? $urandom_range(1, total - 1) : total;
         repeat (n_loads + $urandom_range(0, 2)) send_word(KIND_LOAD, random_pixel());
         repeat (n_fetches) send_word(KIND_FETCH, random_pixel());
      end
      no_gaps = 1'b0;
   endtask

   // Widest frame, then the same store read as the tallest; shrink so the read position restarts
   task automatic test_large_frames();
      int total;
      csr_write(REG_WIDTH, 9'd256);
      csr_write(REG_HEIGHT, 9'd4);
      total = used_dim(width_setting, MAX_WIDTH) * used_dim(height_setting, MAX_HEIGHT);
      no_gaps = 1'b1;
      repeat (total) send_word(KIND_LOAD, random_pixel());
      no_gaps = 1'b0;
      repeat (40) send_word(KIND_FETCH, random_pixel());
      // same pixels as a 4-wide, 256-tall frame: column and row are rebuilt from the count
      csr_write(REG_WIDTH, 9'd4);
      csr_write(REG_HEIGHT, 9'd511);
      repeat (60) send_word(KIND_FETCH, random_pixel());
      // shrink below the read position, then read the small frame to its end
      csr_write(REG_WIDTH, 9'd8);
      csr_write(REG_HEIGHT, 9'd4);
      repeat (32) send_word(KIND_FETCH, random_pixel());
   endtask

   // Compare each strobed pixel with the oldest expectation
   always @(posedge clock) begin
      blurred_pixel_type want;
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected blurred pixel %h %h %h last %b",
                   rsp_red_out, rsp_green_out, rsp_blue_out, rsp_last_pixel);
            failures++;
         end else begin
            want = pending_pixels.pop_front();
            results_checked++;
            if (rsp_red_out !== want.red) begin
               $error("red_out: expected %0d, got %0d", want.red, rsp_red_out);
               failures++;
            end
            if (rsp_green_out !== want.green) begin
               $error("green_out: expected %0d, got %0d", want.green, rsp_green_out);
               failures++;
            end
            if (rsp_blue_out !== want.blue) begin
               $error("blue_out: expected %0d, got %0d", want.blue, rsp_blue_out);
               failures++;
            end
            if (rsp_last_pixel !== want.last) begin
               $error("last_pixel: expected %0d, got %0d", want.last, rsp_last_pixel);
               failures++;
            end
         end
      end
   end

   // Watchdog: give up after a long stretch with no word, pixel or register access
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_directed_frame();
      test_random_frames();
      test_large_frames();
      settle();
      $display("Loaded %0d pixels (%0d dropped), served %0d fetches (%0d dropped),",
               loads_taken, loads_dropped, fetches_served, fetches_dropped);
      $display("frames from 4x4 to 256 wide and 256 tall; %0d blurred pixels compared.",
               results_checked);
      if (failures == 0 && pending_pixels.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/sbb_pkg.sv
rtl/core/sbb_csr.sv
rtl/core/sbb_ram.sv
rtl/core/sbb_acc.sv
rtl/core/sbb_seq.sv
rtl/core/separable_binomial_blur_wrap_top.sv
rtl/core/sbb_check.sv
verif/testbench.sv
